>>> sv/fsac_pkg.sv
// Shared codes, reset values and default sizes for the fire and smoke alarm controller.
`default_nettype none

package fsac_pkg;

    // item kinds
    localparam logic [1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_COMMAND = 2'd2;

    // command codes
    localparam logic [2:0] CMD_FAN_AUTO     = 3'd0;
    localparam logic [2:0] CMD_FAN_ON       = 3'd1;
    localparam logic [2:0] CMD_FAN_OFF      = 3'd2;
    localparam logic [2:0] CMD_REMOTE_SET   = 3'd3;
    localparam logic [2:0] CMD_REMOTE_CLEAR = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TEMP_LIMIT  = 1'd0;
    localparam t_cfg_idx CFG_SMOKE_LIMIT = 1'd1;

    localparam int CFG_DATA_W = 8;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_data TEMP_LIMIT_RST  = 8'd50;
    localparam t_cfg_data SMOKE_LIMIT_RST = 8'd40;

    // default sizes
    localparam int DEF_CAL_SAMPLES = 20;
    localparam int DEF_AVG_SAMPLES = 100;
    localparam int DEF_BLINK_TICKS = 25;
    localparam int DEF_TICK_WRAP   = 200;

    // scaling of the averaged readings
    localparam logic [18:0] TEMP_SCALE = 19'd500;
    localparam logic [18:0] TEMP_ROUND = 19'd512;
    localparam logic [16:0] SMOKE_SCALE = 17'd100;
    localparam logic [6:0]  SMOKE_FLOOR = 7'd2;
    localparam logic [6:0]  SMOKE_CEIL  = 7'd100;

endpackage

`default_nettype wire

>>> sv/fire_smoke_alarm_controller_top.sv
// Top level of the fire and smoke alarm controller: handshake, state and evaluation.
`default_nettype none

// Fire and smoke alarm controller. Each input word is a sample pair, a timer
// tick or a command, and each one yields exactly one result word that shows
// the alarm, safe lamp, fan, warning lamp, latest temperature and smoke
// percent, a flag for a freshly completed average and the calibration flag.
// The first CAL_SAMPLES smoke readings set the smoke baseline; afterwards
// every AVG_SAMPLES pairs give a new measurement and a safety evaluation.
// Rate: one word per clock while the result sink does not stall. An accepted
// word is held in the input register until it advances; then one evaluation
// pass updates the state and registers its result word. The input stalls
// only while the input register holds a word and the result word ahead of
// it waits on a stalled sink. The limits must be written through the config
// port only while the block is idle; the block does not enforce this and drops
// a write when a word advances. A write re-evaluates the safety state at once.
module fire_smoke_alarm_controller_top #(
    parameter int CAL_SAMPLES = fsac_pkg::DEF_CAL_SAMPLES,
    parameter int AVG_SAMPLES = fsac_pkg::DEF_AVG_SAMPLES,
    parameter int BLINK_TICKS = fsac_pkg::DEF_BLINK_TICKS,
    parameter int TICK_WRAP   = fsac_pkg::DEF_TICK_WRAP
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_mode,
    input  wire logic [9:0]          i_temperature_sample,
    input  wire logic [9:0]          i_smoke_sample,
    input  wire logic [2:0]          i_command_code,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_alarm_on,
    output logic                     o_safe_lamp,
    output logic                     o_fan_on,
    output logic                     o_warning_lamp,
    output logic [8:0]               o_temperature_c,
    output logic [6:0]               o_smoke_pct,
    output logic                     o_measurement_valid,
    output logic                     o_calibrated,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire fsac_pkg::t_cfg_idx  i_cfg_idx,
    input  wire fsac_pkg::t_cfg_data i_cfg_data
);
    import fsac_pkg::*;

    // counter and accumulator widths
    localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
    localparam int BSUM_W  = 10 + CNT_W;
    localparam int AVGC_W  = $clog2(AVG_SAMPLES + 1);
    localparam int SUM_W   = 10 + AVGC_W;
    localparam int BLINK_W = (BLINK_TICKS > 1) ? $clog2(BLINK_TICKS) : 1;

    // floor division by a constant: multiply by a rounded-up reciprocal
    localparam int CAL_S = BSUM_W + $clog2(CAL_SAMPLES);
    localparam longint unsigned CAL_M_FULL =
        ((64'd1 << CAL_S) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam logic [BSUM_W:0] CAL_M = CAL_M_FULL[BSUM_W:0];
    localparam int CAL_P_W = 2 * BSUM_W + 1;

    localparam int AVG_S = SUM_W + $clog2(AVG_SAMPLES);
    localparam longint unsigned AVG_M_FULL =
        ((64'd1 << AVG_S) + AVG_SAMPLES - 1) / AVG_SAMPLES;
    localparam logic [SUM_W:0] AVG_M = AVG_M_FULL[SUM_W:0];
    localparam int AVG_P_W = 2 * SUM_W + 1;

    typedef struct packed {
        logic alarming;
        logic fan_state;
        logic warning_state;
    } t_eval;

    // input register
    logic       r_s1_valid;
    logic [1:0] r_s1_mode;
    logic [9:0] r_s1_temp;
    logic [9:0] r_s1_smoke;
    logic [2:0] r_s1_cmd;

    // state
    t_cfg_data          r_temp_limit, n_temp_limit;
    t_cfg_data          r_smoke_limit, n_smoke_limit;
    logic [CNT_W-1:0]   r_cal_count, n_cal_count;
    logic [BSUM_W-1:0]  r_bsum, n_bsum;
    logic [9:0]         r_baseline, n_baseline;
    logic [AVGC_W-1:0]  r_avg_count, n_avg_count;
    logic [SUM_W-1:0]   r_tsum, n_tsum;
    logic [SUM_W-1:0]   r_ssum, n_ssum;
    logic [8:0]         r_cur_temp, n_cur_temp;
    logic [6:0]         r_cur_smoke, n_cur_smoke;
    logic               r_alarming, n_alarming;
    logic               r_fan_auto, n_fan_auto;
    logic               r_fan_state, n_fan_state;
    logic               r_remote, n_remote;
    logic               r_warning, n_warning;
    logic [7:0]         r_tick, n_tick;
    logic [BLINK_W-1:0] r_blink_phase, n_blink_phase;
    logic               r_out_valid;
    logic               r_mvalid, n_mvalid;

    logic               adv;
    logic               in_take;

    // arithmetic intermediates
    logic [CAL_P_W-1:0] cal_prod;
    logic [AVG_P_W-1:0] tavg_prod;
    logic [AVG_P_W-1:0] savg_prod;
    logic [9:0]         tavg;
    logic [9:0]         savg;
    logic [9:0]         sdiff;
    logic [18:0]        temp_scaled;
    logic [16:0]        smoke_scaled;
    logic [6:0]         smoke_raw;
    logic [BLINK_W:0]   phase_inc;
    t_eval              ev;

    // Evaluate danger from the given readings and limits.
    function automatic t_eval evaluate(
        input logic [8:0] temp,
        input logic [6:0] smoke,
        input t_cfg_data  temp_lim,
        input t_cfg_data  smoke_lim,
        input logic       remote,
        input logic       fan_auto,
        input logic       fan_state,
        input logic       warning
    );
        logic  hot;
        logic  gas;
        t_eval res;
        hot = temp >= {1'b0, temp_lim};
        gas = {1'b0, smoke} >= smoke_lim;
        res.alarming      = hot | gas | remote;
        res.warning_state = res.alarming & warning;
        res.fan_state     = fan_auto ? (hot & ~gas) : fan_state;
        return res;
    endfunction

    // Advance the evaluation stage when the result slot is free or draining.
    assign adv        = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & ~adv;
    assign in_take    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_mode  <= i_mode;
            r_s1_temp  <= i_temperature_sample;
            r_s1_smoke <= i_smoke_sample;
            r_s1_cmd   <= i_command_code;
        end
    end

    always_comb begin
        n_temp_limit  = r_temp_limit;
        n_smoke_limit = r_smoke_limit;
        n_cal_count   = r_cal_count;
        n_bsum        = r_bsum;
        n_baseline    = r_baseline;
        n_avg_count   = r_avg_count;
        n_tsum        = r_tsum;
        n_ssum        = r_ssum;
        n_cur_temp    = r_cur_temp;
        n_cur_smoke   = r_cur_smoke;
        n_alarming    = r_alarming;
        n_fan_auto    = r_fan_auto;
        n_fan_state   = r_fan_state;
        n_remote      = r_remote;
        n_warning     = r_warning;
        n_tick        = r_tick;
        n_blink_phase = r_blink_phase;
        n_mvalid      = 1'b0;

        // sample path: accumulate and scale
        n_bsum    = r_bsum + BSUM_W'(r_s1_smoke);
        cal_prod  = {{(BSUM_W+1){1'b0}}, n_bsum} * {{(BSUM_W){1'b0}}, CAL_M};
        n_tsum    = r_tsum + SUM_W'(r_s1_temp);
        n_ssum    = r_ssum + SUM_W'(r_s1_smoke);
        tavg_prod = {{(SUM_W+1){1'b0}}, n_tsum} * {{SUM_W{1'b0}}, AVG_M};
        savg_prod = {{(SUM_W+1){1'b0}}, n_ssum} * {{SUM_W{1'b0}}, AVG_M};
        tavg      = tavg_prod[AVG_S +: 10];
        savg      = savg_prod[AVG_S +: 10];
        sdiff     = (savg > r_baseline) ? (savg - r_baseline) : 10'd0;
        temp_scaled  = {9'd0, tavg} * TEMP_SCALE + TEMP_ROUND;
        smoke_scaled = {7'd0, sdiff} * SMOKE_SCALE;
        smoke_raw    = smoke_scaled[16:10];
        // hold the accumulators unless the sample path is taken
        n_bsum = r_bsum;
        n_tsum = r_tsum;
        n_ssum = r_ssum;

        // tick path: track tick count modulo the blink period
        phase_inc = {1'b0, r_blink_phase} + 1'b1;

        ev = evaluate(r_cur_temp, r_cur_smoke, r_temp_limit, r_smoke_limit,
                      r_remote, r_fan_auto, r_fan_state, r_warning);

        if (adv) begin
            case (r_s1_mode)
                MODE_SAMPLE: begin
                    if (r_cal_count < CNT_W'(CAL_SAMPLES)) begin
                        n_bsum      = r_bsum + BSUM_W'(r_s1_smoke);
                        n_cal_count = r_cal_count + 1'b1;
                        if (n_cal_count == CNT_W'(CAL_SAMPLES)) begin
                            n_baseline = cal_prod[CAL_S +: 10];
                        end
                    end else begin
                        n_tsum      = r_tsum + SUM_W'(r_s1_temp);
                        n_ssum      = r_ssum + SUM_W'(r_s1_smoke);
                        n_avg_count = r_avg_count + 1'b1;
                        if (n_avg_count == AVGC_W'(AVG_SAMPLES)) begin
                            n_cur_temp = temp_scaled[18:10];
                            if (smoke_raw <= SMOKE_FLOOR) begin
                                n_cur_smoke = 7'd0;
                            end else if (smoke_raw > SMOKE_CEIL) begin
                                n_cur_smoke = SMOKE_CEIL;
                            end else begin
                                n_cur_smoke = smoke_raw;
                            end
                            n_tsum      = '0;
                            n_ssum      = '0;
                            n_avg_count = '0;
                            n_mvalid    = 1'b1;
                            ev = evaluate(n_cur_temp, n_cur_smoke, r_temp_limit,
                                          r_smoke_limit, r_remote, r_fan_auto,
                                          r_fan_state, r_warning);
                            n_alarming  = ev.alarming;
                            n_fan_state = ev.fan_state;
                            n_warning   = ev.warning_state;
                        end
                    end
                end
                MODE_TICK: begin
                    n_tick = r_tick + 8'd1;
                    if (phase_inc == (BLINK_W + 1)'(BLINK_TICKS)) begin
                        n_blink_phase = '0;
                        if (r_alarming) begin
                            n_warning = ~r_warning;
                        end
                    end else begin
                        n_blink_phase = phase_inc[BLINK_W-1:0];
                    end
                    if (n_tick >= 8'(TICK_WRAP)) begin
                        n_tick        = '0;
                        n_blink_phase = '0;
                    end
                end
                MODE_COMMAND: begin
                    case (r_s1_cmd)
                        CMD_FAN_AUTO: begin
                            n_fan_auto = 1'b1;
                            ev = evaluate(r_cur_temp, r_cur_smoke, r_temp_limit,
                                          r_smoke_limit, r_remote, 1'b1,
                                          r_fan_state, r_warning);
                            n_alarming  = ev.alarming;
                            n_fan_state = ev.fan_state;
                            n_warning   = ev.warning_state;
                        end
                        CMD_FAN_ON: begin
                            n_fan_auto  = 1'b0;
                            n_fan_state = 1'b1;
                        end
                        CMD_FAN_OFF: begin
                            n_fan_auto  = 1'b0;
                            n_fan_state = 1'b0;
                        end
                        CMD_REMOTE_SET, CMD_REMOTE_CLEAR: begin
                            n_remote = (r_s1_cmd == CMD_REMOTE_SET);
                            ev = evaluate(r_cur_temp, r_cur_smoke, r_temp_limit,
                                          r_smoke_limit, n_remote, r_fan_auto,
                                          r_fan_state, r_warning);
                            n_alarming  = ev.alarming;
                            n_fan_state = ev.fan_state;
                            n_warning   = ev.warning_state;
                        end
                        default: begin
                            // drop unknown commands
                        end
                    endcase
                end
                default: begin
                    // drop unknown item kinds, still answer with a word
                end
            endcase
        end else if (i_cfg_we) begin
            // apply the new limit and re-evaluate at once
            case (i_cfg_idx)
                CFG_TEMP_LIMIT: begin
                    n_temp_limit = i_cfg_data;
                end
                CFG_SMOKE_LIMIT: begin
                    n_smoke_limit = i_cfg_data;
                end
                default: begin
                end
            endcase
            ev = evaluate(r_cur_temp, r_cur_smoke, n_temp_limit, n_smoke_limit,
                          r_remote, r_fan_auto, r_fan_state, r_warning);
            n_alarming  = ev.alarming;
            n_fan_state = ev.fan_state;
            n_warning   = ev.warning_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mvalid      <= 1'b0;
            r_temp_limit  <= TEMP_LIMIT_RST;
            r_smoke_limit <= SMOKE_LIMIT_RST;
            r_cal_count   <= '0;
            r_bsum        <= '0;
            r_baseline    <= '0;
            r_avg_count   <= '0;
            r_tsum        <= '0;
            r_ssum        <= '0;
            r_cur_temp    <= '0;
            r_cur_smoke   <= '0;
            r_alarming    <= 1'b0;
            r_fan_auto    <= 1'b1;
            r_fan_state   <= 1'b0;
            r_remote      <= 1'b0;
            r_warning     <= 1'b0;
            r_tick        <= '0;
            r_blink_phase <= '0;
        end else begin
            // load the input register whenever it is not held
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            // raise a result word per advanced item, drop it once taken
            if (adv) begin
                r_out_valid <= 1'b1;
                r_mvalid    <= n_mvalid;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_temp_limit  <= n_temp_limit;
            r_smoke_limit <= n_smoke_limit;
            r_cal_count   <= n_cal_count;
            r_bsum        <= n_bsum;
            r_baseline    <= n_baseline;
            r_avg_count   <= n_avg_count;
            r_tsum        <= n_tsum;
            r_ssum        <= n_ssum;
            r_cur_temp    <= n_cur_temp;
            r_cur_smoke   <= n_cur_smoke;
            r_alarming    <= n_alarming;
            r_fan_auto    <= n_fan_auto;
            r_fan_state   <= n_fan_state;
            r_remote      <= n_remote;
            r_warning     <= n_warning;
            r_tick        <= n_tick;
            r_blink_phase <= n_blink_phase;
        end
    end

    // The state moves only when a word advances or a limit write is applied.
    assign o_out_valid         = r_out_valid;
    assign o_alarm_on          = r_alarming;
    assign o_safe_lamp         = ~r_alarming;
    assign o_fan_on            = r_fan_state;
    assign o_warning_lamp      = r_warning;
    assign o_temperature_c     = r_cur_temp;
    assign o_smoke_pct         = r_cur_smoke;
    assign o_measurement_valid = r_mvalid;
    assign o_calibrated        = (r_cal_count >= CNT_W'(CAL_SAMPLES));

endmodule

`default_nettype wire
